>>> src/sobh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobh_pkg: shared types and constants
// Register indexes, field widths and the per-item control flags that travel
// from the front end through the work queue to the gradient datapath.
// ----------------------------------------------------------------------------
package sobh_pkg;

  localparam int MAX_WIDTH_DEF = 512;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int PIX_W         = 8;
  localparam int FWIDTH_W      = 10;
  localparam int FHEIGHT_W     = 13;
  localparam int ROW_W         = 12;
  localparam int CFG_INDEX_W   = 8;
  localparam int CFG_DATA_W    = 13;
  localparam int WORK_DEPTH    = 2;
  localparam int RESULT_DEPTH  = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

  localparam logic [FWIDTH_W-1:0]  FRAME_WIDTH_RST  = FWIDTH_W'(512);
  localparam logic [FHEIGHT_W-1:0] FRAME_HEIGHT_RST = FHEIGHT_W'(512);

  localparam logic [PIX_W-1:0] SAT_LEVEL = 8'd255;

  // Classification made by the front end for each item.
  typedef struct packed {
    logic emit;       // centre pixel is interior, a result is produced
    logic frame_end;  // result is the last one of the frame
  } sobh_ctrl_t;

  typedef struct packed {
    logic [PIX_W-1:0] magnitude;
    logic             frame_end;
  } sobh_result_t;

endpackage

>>> src/sobh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobh_queue: small first-in first-out queue
// Register-based queue with push/full and pop/empty; the head entry is
// always presented on rdata while empty is low.
// ----------------------------------------------------------------------------
module sobh_queue import sobh_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

>>> src/sobh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobh_front: frame registers, raster counters and item classification
// Holds the frame size registers, tracks the column and row of the next
// pixel and tags each accepted item with its column and result flags.
// ----------------------------------------------------------------------------
module sobh_front import sobh_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int COL_W     = $clog2(MAX_WIDTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  input  logic                   work_full,
  output logic                   work_push,
  output logic [COL_W-1:0]       work_col,
  output sobh_ctrl_t             work_ctrl
);

  logic [FWIDTH_W-1:0]  frame_width;
  logic [FHEIGHT_W-1:0] frame_height;
  logic [COL_W-1:0]     column_count;
  logic [ROW_W-1:0]     row_count;
  logic [COL_W-1:0]     last_col;
  logic [ROW_W-1:0]     last_row;
  logic [31:0]          width_use;
  logic [31:0]          height_use;

  // Width and height in use are the registers clamped to their legal range.
  always_comb begin
    width_use = 32'(frame_width);
    if (width_use < 32'd3) begin
      width_use = 32'd3;
    end
    if (width_use > 32'(MAX_WIDTH)) begin
      width_use = 32'(MAX_WIDTH);
    end
    height_use = 32'(frame_height);
    if (height_use < 32'd3) begin
      height_use = 32'd3;
    end
    if (height_use > 32'(HEIGHT_LIMIT)) begin
      height_use = 32'(HEIGHT_LIMIT);
    end
    last_col = COL_W'(width_use - 32'd1);
    last_row = ROW_W'(height_use - 32'd1);
  end

  assign work_push           = push && !work_full;
  assign work_col            = column_count;
  assign work_ctrl.emit      = (row_count >= ROW_W'(2)) && (column_count >= COL_W'(2));
  assign work_ctrl.frame_end = (row_count == last_row) && (column_count == last_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_valid) begin
      // A write to a known register restarts the frame.
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width  <= cfg_data[FWIDTH_W-1:0];
          column_count <= '0;
          row_count    <= '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[FHEIGHT_W-1:0];
          column_count <= '0;
          row_count    <= '0;
        end
        default: begin
        end
      endcase
    end else if (work_push) begin
      if (column_count == last_col) begin
        column_count <= '0;
        row_count    <= (row_count == last_row) ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

endmodule

>>> src/sobh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobh_back: line stores, 3x3 window and gradient datapath
// Reads both line stores for the item at the head of the work queue, then
// forms the horizontal Sobel gradient, ages the line stores and shifts the
// window in the following stage.
// ----------------------------------------------------------------------------
module sobh_back import sobh_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int COL_W     = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             work_empty,
  input  logic [PIX_W-1:0] work_pixel,
  input  logic [COL_W-1:0] work_col,
  input  sobh_ctrl_t       work_ctrl,
  output logic             work_pop,
  input  logic             result_full,
  output logic             result_push,
  output sobh_result_t     result
);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

  logic             stage_valid;
  logic [PIX_W-1:0] stage_pixel;
  logic [COL_W-1:0] stage_col;
  sobh_ctrl_t       stage_ctrl;
  logic [PIX_W-1:0] top_q;
  logic [PIX_W-1:0] mid_q;
  logic [PIX_W-1:0] win [6];
  logic             stage_fire;
  logic             rd_en;
  logic signed [10:0] grad;
  logic        [10:0] grad_abs;

  assign stage_fire = stage_valid && (!stage_ctrl.emit || !result_full);
  assign rd_en      = !work_empty && (!stage_valid || stage_fire);
  assign work_pop   = rd_en;

  // Line store read data is only refreshed when a new item enters the stage,
  // so it holds while the stage waits on the result queue.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      top_q       <= upper_mem[work_col];
      mid_q       <= lower_mem[work_col];
      stage_pixel <= work_pixel;
      stage_col   <= work_col;
      stage_ctrl  <= work_ctrl;
    end
    if (stage_fire) begin
      upper_mem[stage_col] <= mid_q;
      lower_mem[stage_col] <= stage_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      for (int k = 0; k < 6; k++) begin
        win[k] <= '0;
      end
    end else begin
      if (rd_en) begin
        stage_valid <= 1'b1;
      end else if (stage_fire) begin
        stage_valid <= 1'b0;
      end
      if (stage_fire) begin
        win[0] <= win[3];
        win[1] <= win[4];
        win[2] <= win[5];
        win[3] <= top_q;
        win[4] <= mid_q;
        win[5] <= stage_pixel;
      end
    end
  end

  // Left column minus right column, middle row weighted by two.
  always_comb begin
    grad = (signed'({3'b000, win[0]}) - signed'({3'b000, top_q}))
         + ((signed'({3'b000, win[1]}) - signed'({3'b000, mid_q})) <<< 1)
         + (signed'({3'b000, win[2]}) - signed'({3'b000, stage_pixel}));
    grad_abs = (grad < 0) ? 11'(-grad) : 11'(grad);
    if (grad_abs > 11'(SAT_LEVEL)) begin
      result.magnitude = SAT_LEVEL;
    end else begin
      result.magnitude = grad_abs[PIX_W-1:0];
    end
    result.frame_end = stage_ctrl.frame_end;
  end

  assign result_push = stage_fire && stage_ctrl.emit;

endmodule

>>> src/sobel_horizontal_gradient_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_horizontal_gradient_3x3: horizontal Sobel gradient magnitude
// Streams raster pixels through two line stores and a 3x3 window and returns
// one saturated gradient byte per interior centre pixel.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while the result queue is not full, set by the
// single read port of each line store, which is read once per item.
// Path: a window's last pixel passes the work queue and the registered stage,
// which reads both line stores, and its result enters the output queue.
// Reset: frame size returns to 512 x 512, counters and queues clear; the
// line stores are not cleared and need no clearing pass.
module sobel_horizontal_gradient_3x3 import sobh_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [PIX_W-1:0]       pixel,
  output logic                   empty,
  input  logic                   pop,
  output logic [PIX_W-1:0]       magnitude,
  output logic                   frame_end
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WORK_W = PIX_W + COL_W + $bits(sobh_ctrl_t);

  logic              work_push;
  logic [COL_W-1:0]  front_col;
  sobh_ctrl_t        front_ctrl;
  logic              work_full;
  logic              work_empty;
  logic              work_pop;
  logic [WORK_W-1:0] work_rdata;
  logic [PIX_W-1:0]  work_pixel;
  logic [COL_W-1:0]  work_col;
  sobh_ctrl_t        work_ctrl;
  logic              result_full;
  logic              result_push;
  sobh_result_t      result_in;
  sobh_result_t      result_out;

  assign cfg_ready = 1'b1;
  assign full      = work_full;

  sobh_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .work_full (work_full),
    .work_push (work_push),
    .work_col  (front_col),
    .work_ctrl (front_ctrl)
  );

  sobh_queue #(
    .W     (WORK_W),
    .DEPTH (WORK_DEPTH)
  ) u_work_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (work_push),
    .wdata ({pixel, front_col, front_ctrl}),
    .full  (work_full),
    .pop   (work_pop),
    .rdata (work_rdata),
    .empty (work_empty)
  );

  assign {work_pixel, work_col, work_ctrl} = work_rdata;

  sobh_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .work_empty  (work_empty),
    .work_pixel  (work_pixel),
    .work_col    (work_col),
    .work_ctrl   (work_ctrl),
    .work_pop    (work_pop),
    .result_full (result_full),
    .result_push (result_push),
    .result      (result_in)
  );

  sobh_queue #(
    .W     ($bits(sobh_result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (result_push),
    .wdata (result_in),
    .full  (result_full),
    .pop   (pop),
    .rdata (result_out),
    .empty (empty)
  );

  assign magnitude = result_out.magnitude;
  assign frame_end = result_out.frame_end;

endmodule

>>> tb/sobel_horizontal_gradient_3x3_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_horizontal_gradient_3x3_tb: self-checking bench for the Sobel block
// Streams raster pixel frames of many sizes into the block, predicts every
// interior gradient byte and end-of-frame flag in a cycle-free model of the
// line stores and window, and compares each popped item in order. The sender
// works in bursts and the receiver stalls on shifting masks.
// ----------------------------------------------------------------------------
module sobel_horizontal_gradient_3x3_tb;
  import sobh_pkg::*;

  localparam int IDLE_SETTLE  = 8;
  localparam int RANDOM_ITEMS = 120;
  localparam int MAX_PRINTS   = 100;

  typedef enum int {PIX_UNIFORM, PIX_BINARY, PIX_FLAT} pixel_mix_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic [PIX_W-1:0]       pixel = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [PIX_W-1:0]       magnitude;
  logic                   frame_end;

  // Predictor state: a copy of the block's frame registers, stores and window.
  logic [PIX_W-1:0]     line_upper [MAX_WIDTH_DEF] = '{default: '0};
  logic [PIX_W-1:0]     line_lower [MAX_WIDTH_DEF] = '{default: '0};
  logic [PIX_W-1:0]     win [6] = '{default: '0};
  logic [FWIDTH_W-1:0]  width_reg = FRAME_WIDTH_RST;
  logic [FHEIGHT_W-1:0] height_reg = FRAME_HEIGHT_RST;
  int unsigned          col_pos = 0;
  int unsigned          row_pos = 0;

  logic [PIX_W-1:0] pixel_backlog [$];
  sobh_result_t     expected_grads [$];

  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] pop_mask = 16'hFFFF;
  logic [5:0]  mask_cycle = '0;
  logic        hold_off = 1'b0;

  sobel_horizontal_gradient_3x3 dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .empty     (empty),
    .pop       (pop),
    .magnitude (magnitude),
    .frame_end (frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_reg;
    if (h < 3) h = 3;
    if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    return h;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Advances the model by one pixel and queues the gradient it produces.
  task automatic gradient_step(input logic [PIX_W-1:0] px);
    int unsigned w, h, c, r;
    int g;
    logic [PIX_W-1:0] top, mid;
    sobh_result_t res;
    w = eff_width();
    h = eff_height();
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    top = line_upper[c];
    mid = line_lower[c];
    if (r >= 2 && c >= 2) begin
      g = (int'(win[0]) - int'(top)) + 2 * (int'(win[1]) - int'(mid))
          + (int'(win[2]) - int'(px));
      if (g < 0) g = -g;
      res.magnitude = (g > 255) ? SAT_LEVEL : PIX_W'(g);
      res.frame_end = (r == h - 1) && (c == w - 1);
      expected_grads.push_back(res);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = px;
    line_upper[c] = mid;
    line_lower[c] = px;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // Only the two frame registers restart the raster position.
    if (idx == REG_FRAME_WIDTH) begin
      width_reg = data[FWIDTH_W-1:0];
      col_pos = 0;
      row_pos = 0;
    end else if (idx == REG_FRAME_HEIGHT) begin
      height_reg = data;
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pixel_backlog.size() != 0 || push || expected_grads.size() != 0);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic queue_pixels(input int unsigned count, input pixel_mix_t mix);
    logic [PIX_W-1:0] base;
    base = PIX_W'($urandom);
    repeat (count) begin
      case (mix)
        PIX_BINARY: pixel_backlog.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
        PIX_FLAT:   pixel_backlog.push_back(base ^ PIX_W'($urandom_range(0, 3)));
        default:    pixel_backlog.push_back(PIX_W'($urandom));
      endcase
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_width();
    int unsigned w;
    case ($urandom_range(0, 9))
      0:       w = $urandom_range(0, 2);
      1:       w = MAX_WIDTH_DEF;
      2:       w = $urandom_range(MAX_WIDTH_DEF + 1, 1023);
      default: w = $urandom_range(3, 12);
    endcase
    // Bits above the register width are don't-care and get random values.
    return {3'($urandom), FWIDTH_W'(w)};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0:       return CFG_DATA_W'($urandom_range(0, 2));
      1:       return CFG_DATA_W'(HEIGHT_LIMIT);
      2:       return CFG_DATA_W'($urandom_range(HEIGHT_LIMIT + 1, 8191));
      default: return CFG_DATA_W'($urandom_range(3, 8));
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (push && !full) gradient_step(pixel);
      if (!(push && full)) begin
        if (gap_left != 0) begin
          push <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pixel_backlog.size() != 0) begin
          push <= 1'b1;
          pixel <= pixel_backlog.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 48);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: pops on a 16-bit mask, indexed by a wrapping counter and redrawn on each wrap.
  always @(posedge clk) begin
    sobh_result_t exp_res;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen <= results_seen + 1;
        if (expected_grads.size() == 0) begin
          report_mismatch($sformatf("unexpected item, magnitude %0d frame_end %0b",
                                    magnitude, frame_end));
        end else begin
          exp_res = expected_grads.pop_front();
          if (magnitude !== exp_res.magnitude)
            report_mismatch($sformatf("magnitude %0d, expected %0d",
                                      magnitude, exp_res.magnitude));
          if (frame_end !== exp_res.frame_end)
            report_mismatch($sformatf("frame_end %0b, expected %0b",
                                      frame_end, exp_res.frame_end));
        end
      end
      if (mask_cycle == 6'd63)
        pop_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      mask_cycle <= mask_cycle + 1'b1;
      pop <= !hold_off && pop_mask[mask_cycle[3:0]];
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin
    wait (results_seen >= 200);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("sobel_horizontal_gradient_3x3_tb: FAIL");
    $finish;
  end

  initial begin
    int unsigned random_items;
    int unsigned n, split;
    pixel_mix_t mix;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Width out of reset is 512: widest frame, three rows, up to its end flag.
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
    queue_pixels(3 * MAX_WIDTH_DEF, PIX_UNIFORM);
    wait_idle();

    // Sizes below the range clamp to 3 x 3; strong positive edge saturates.
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(0));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
    repeat (3) begin
      pixel_backlog.push_back(8'hFF);
      pixel_backlog.push_back(PIX_W'($urandom));
      pixel_backlog.push_back(8'h00);
    end
    wait_idle();

    // Height above the range clamps to 4096, so no frame end is flagged.
    // A write to an unused index mid-frame must not restart the frame.
    write_reg(REG_FRAME_WIDTH, 13'h1C03);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    pixel_backlog.push_back(8'h00);
    pixel_backlog.push_back(PIX_W'($urandom));
    pixel_backlog.push_back(8'hFF);
    pixel_backlog.push_back(8'h00);
    wait_idle();
    write_reg(CFG_INDEX_W'(2), 13'h1FFF);
    pixel_backlog.push_back(PIX_W'($urandom));
    pixel_backlog.push_back(8'hFF);
    pixel_backlog.push_back(8'h00);
    pixel_backlog.push_back(PIX_W'($urandom));
    pixel_backlog.push_back(8'hFF);

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_WIDTH, pick_width());
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_HEIGHT, pick_height());
      mix = pixel_mix_t'($urandom_range(0, 2));
      // Wide frames are slow to reach interior rows; keep those phases short.
      n = (eff_width() > 16) ? $urandom_range(1, 40) : $urandom_range(3 * eff_width(), 160);
      if ($urandom_range(0, 2) == 0) begin
        split = $urandom_range(1, n);
        queue_pixels(split, mix);
        wait_idle();
        write_reg(CFG_INDEX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
        queue_pixels(n - split, mix);
      end else begin
        queue_pixels(n, mix);
      end
      random_items += n;
    end
    wait_idle();
    repeat (IDLE_SETTLE) @(posedge clk);

    if (fail_count == 0) begin
      $display("sobel_horizontal_gradient_3x3_tb: PASS");
    end else begin
      $display("sobel_horizontal_gradient_3x3_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/sobh_pkg.sv
src/sobh_queue.sv
src/sobh_front.sv
src/sobh_back.sv
src/sobel_horizontal_gradient_3x3.sv
tb/sobel_horizontal_gradient_3x3_tb.sv
